@@ rtl/core/tdfsm_pkg.sv @@
// Shared types, sizes and command codes for the table-driven FSM engine.
`timescale 1ns / 1ps

package tdfsm_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int STATE_BITS  = 8;
  localparam int EVENT_BITS  = 8;
  localparam int ACTION_BITS = 8;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] CMD_DISPATCH = 2'd0;
  localparam logic [1:0] CMD_REGISTER = 2'd1;
  localparam logic [1:0] CMD_RESET    = 2'd2;
  localparam logic [1:0] CMD_SET      = 2'd3;

  typedef logic [STATE_BITS-1:0]  state_t;
  typedef logic [EVENT_BITS-1:0]  event_t;
  typedef logic [ACTION_BITS-1:0] action_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef struct packed {
    state_t  from_state;
    event_t  evt;
    state_t  nxt_state;
    action_t act;
  } entry_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    entry_t data;
  } tbl_wr_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
  } tbl_rd_t;

  typedef struct packed {
    logic    ok;
    state_t  cur_state;
    action_t act;
  } res_t;

endpackage

@@ rtl/core/tdfsm_table.sv @@
// Transition table storage: one write port, one registered read port.
`timescale 1ns / 1ps

module tdfsm_table (
  input  logic               clk,
  input  tdfsm_pkg::tbl_wr_t wr,
  input  tdfsm_pkg::tbl_rd_t rd,
  output tdfsm_pkg::entry_t  rd_data
);

  tdfsm_pkg::entry_t mem [tdfsm_pkg::TABLE_DEPTH];
  tdfsm_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/tdfsm_ctrl.sv @@
// Command sequencer: state and fill count, table append, first-match scan.
`timescale 1ns / 1ps

module tdfsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  tdfsm_pkg::event_t  evt,
  input  tdfsm_pkg::state_t  from_state,
  input  tdfsm_pkg::state_t  to_state,
  input  tdfsm_pkg::action_t act,
  output tdfsm_pkg::tbl_wr_t wr,
  output tdfsm_pkg::tbl_rd_t rd,
  input  tdfsm_pkg::entry_t  rd_data,
  output logic               res_valid,
  output tdfsm_pkg::res_t    res,
  input  logic               res_free
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } seq_st_t;

  seq_st_t              st_r, st_nxt;
  tdfsm_pkg::state_t    cur_r, cur_nxt;
  tdfsm_pkg::cnt_t      cnt_r, cnt_nxt;
  tdfsm_pkg::cnt_t      iss_r, iss_nxt;
  tdfsm_pkg::cnt_t      cmp_r, cmp_nxt;
  logic                 pend_r, pend_nxt;
  tdfsm_pkg::event_t    evt_r, evt_nxt;
  logic                 ok_r, ok_nxt;
  tdfsm_pkg::action_t   act_r, act_nxt;

  logic accept;
  logic issue;
  logic hit;
  logic last;
  logic full;

  assign accept = in_valid && (st_r == ST_IDLE);
  assign full   = (cnt_r == tdfsm_pkg::cnt_t'(tdfsm_pkg::TABLE_DEPTH));
  assign issue  = (st_r == ST_SCAN) && (iss_r < cnt_r);
  assign hit    = pend_r && (rd_data.from_state == cur_r) && (rd_data.evt == evt_r);
  assign last   = ((cmp_r + tdfsm_pkg::cnt_t'(1)) == cnt_r);

  // Append goes straight to the table on the accepting edge.
  assign wr.en   = accept && (cmd == tdfsm_pkg::CMD_REGISTER) && !full;
  assign wr.addr = cnt_r[tdfsm_pkg::ADDR_W-1:0];
  assign wr.data = '{from_state: from_state, evt: evt, nxt_state: to_state, act: act};

  assign rd.en   = issue;
  assign rd.addr = iss_r[tdfsm_pkg::ADDR_W-1:0];

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    cnt_nxt  = cnt_r;
    iss_nxt  = iss_r;
    cmp_nxt  = cmp_r;
    pend_nxt = pend_r;
    evt_nxt  = evt_r;
    ok_nxt   = ok_r;
    act_nxt  = act_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt = '0;
          ok_nxt  = 1'b1;
          st_nxt  = ST_DONE;
          case (cmd)
            tdfsm_pkg::CMD_DISPATCH: begin
              evt_nxt  = evt;
              iss_nxt  = '0;
              pend_nxt = 1'b0;
              if (cnt_r == '0) begin
                ok_nxt = 1'b0;
              end else begin
                st_nxt = ST_SCAN;
              end
            end
            tdfsm_pkg::CMD_REGISTER: begin
              if (full) begin
                ok_nxt = 1'b0;
              end else begin
                cnt_nxt = cnt_r + tdfsm_pkg::cnt_t'(1);
              end
            end
            tdfsm_pkg::CMD_RESET: begin
              cur_nxt = to_state;
              cnt_nxt = '0;
            end
            default: begin
              cur_nxt = to_state;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Read of entry iss_r overlaps the compare of entry cmp_r.
        pend_nxt = issue;
        cmp_nxt  = iss_r;
        if (issue) begin
          iss_nxt = iss_r + tdfsm_pkg::cnt_t'(1);
        end
        if (hit) begin
          cur_nxt = rd_data.nxt_state;
          ok_nxt  = 1'b1;
          act_nxt = rd_data.act;
          st_nxt  = ST_DONE;
        end else if (pend_r && last) begin
          ok_nxt  = 1'b0;
          act_nxt = '0;
          st_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cur_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cur_r  <= cur_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r <= iss_nxt;
    cmp_r <= cmp_nxt;
    evt_r <= evt_nxt;
    ok_r  <= ok_nxt;
    act_r <= act_nxt;
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign res_valid = (st_r == ST_DONE);
  assign res       = '{ok: ok_r, cur_state: cur_r, act: act_r};

endmodule

@@ rtl/core/table_driven_fsm_engine_core.sv @@
// Top level of the table-driven FSM engine: sequencer, table and output register.
// Register, reset and set commands: the result goes from the sequencer's done state into the output register.
// Dispatch: the scan reads one table entry per cycle through the single read port
//   and stops at the first match or after the last stored entry.
// One transaction in flight: the next is accepted in the cycle after the result is loaded,
//   later while out_stall holds the result. Synchronous active-low reset: state 0, empty table.
`timescale 1ns / 1ps

module table_driven_fsm_engine_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_event_code,
  input  logic [7:0] in_from_state,
  input  logic [7:0] in_to_state,
  input  logic [7:0] in_action_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic [7:0] out_cur_state,
  output logic [7:0] out_action_out
);

  tdfsm_pkg::tbl_wr_t wr;
  tdfsm_pkg::tbl_rd_t rd;
  tdfsm_pkg::entry_t  rd_data;
  tdfsm_pkg::res_t    res;
  logic               res_valid;
  logic               res_free;

  logic       out_valid_r;
  logic       out_ok_r;
  logic [7:0] out_cur_state_r;
  logic [7:0] out_action_r;

  assign res_free = !out_valid_r || !out_stall;

  tdfsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (in_cmd),
    .evt        (tdfsm_pkg::event_t'(in_event_code)),
    .from_state (tdfsm_pkg::state_t'(in_from_state)),
    .to_state   (tdfsm_pkg::state_t'(in_to_state)),
    .act        (tdfsm_pkg::action_t'(in_action_id)),
    .wr         (wr),
    .rd         (rd),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res        (res),
    .res_free   (res_free)
  );

  tdfsm_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_ok_r        <= res.ok;
      out_cur_state_r <= 8'(res.cur_state);
      out_action_r    <= 8'(res.act);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_cur_state  = out_cur_state_r;
  assign out_action_out = out_action_r;

`ifndef SYNTHESIS
  // An accepted transaction keeps the engine busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("engine took no busy cycle after a transaction");

  // A failed command never reports an action.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_action_out == 8'd0)
    else $error("action reported without a taken transition");

  // A new result appears only when the sequencer offered one.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_valid))
    else $error("result register loaded without a finished command");
`endif

endmodule

@@ verif/table_driven_fsm_engine_core_tb.sv @@
// Self-checking testbench for the table-driven FSM engine core.
`timescale 1ns / 1ps

module table_driven_fsm_engine_core_tb;

  localparam int          RANDOM_ITEMS = 800;
  localparam int          IDLE_LIMIT   = 5000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0]         cmd;
    tdfsm_pkg::event_t  ev;
    tdfsm_pkg::state_t  from;
    tdfsm_pkg::state_t  to;
    tdfsm_pkg::action_t act;
  } fsm_cmd_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd         = tdfsm_pkg::CMD_DISPATCH;
  logic [7:0] in_event_code  = '0;
  logic [7:0] in_from_state  = '0;
  logic [7:0] in_to_state    = '0;
  logic [7:0] in_action_id   = '0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic       out_ok;
  logic [7:0] out_cur_state;
  logic [7:0] out_action_out;

  table_driven_fsm_engine_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_event_code  (in_event_code),
    .in_from_state  (in_from_state),
    .in_to_state    (in_to_state),
    .in_action_id   (in_action_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_cur_state  (out_cur_state),
    .out_action_out (out_action_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: mirror of the engine
  tdfsm_pkg::state_t fsm_state;
  tdfsm_pkg::cnt_t   fsm_count;
  tdfsm_pkg::entry_t fsm_table [tdfsm_pkg::TABLE_DEPTH];

  fsm_cmd_t          cmd_queue[$];
  tdfsm_pkg::res_t   predicted_replies[$];
  int unsigned mismatch_cnt  = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned in_gap        = 0;
  int unsigned stall_left    = 0;
  int unsigned idle_cycles   = 0;
  logic        calm;

  // Small state/event sets for the random episodes
  tdfsm_pkg::state_t st_pool [8];
  tdfsm_pkg::event_t ev_pool [8];
  int unsigned       n_st = 2;
  int unsigned       n_ev = 2;

  // Every fourth stretch of 50 transactions runs with no idling on either side
  assign calm = ((accepted_cnt / 50) % 4) == 3;

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic tdfsm_pkg::state_t pick_st();
    return st_pool[3'($urandom_range(0, n_st - 1))];
  endfunction

  function automatic tdfsm_pkg::event_t pick_ev();
    return ev_pool[3'($urandom_range(0, n_ev - 1))];
  endfunction

  // Applies one command; a dispatch is a first-match scan over stored entries. Returns the reply and updates state
  function automatic tdfsm_pkg::res_t fsm_apply(logic [1:0] cmd, tdfsm_pkg::event_t ev,
                                                tdfsm_pkg::state_t from,
                                                tdfsm_pkg::state_t to,
                                                tdfsm_pkg::action_t act);
    tdfsm_pkg::res_t reply;
    logic            hit;
    reply = '0;
    hit   = 1'b0;
    case (cmd)
      tdfsm_pkg::CMD_DISPATCH: begin
        for (int i = 0; i < int'(fsm_count); i++) begin
          if (!hit && fsm_table[i[tdfsm_pkg::ADDR_W-1:0]].from_state == fsm_state &&
              fsm_table[i[tdfsm_pkg::ADDR_W-1:0]].evt == ev) begin
            hit       = 1'b1;
            fsm_state = fsm_table[i[tdfsm_pkg::ADDR_W-1:0]].nxt_state;
            reply.act = fsm_table[i[tdfsm_pkg::ADDR_W-1:0]].act;
          end
        end
        reply.ok = hit;
      end
      tdfsm_pkg::CMD_REGISTER: begin
        if (int'(fsm_count) < tdfsm_pkg::TABLE_DEPTH) begin
          fsm_table[fsm_count[tdfsm_pkg::ADDR_W-1:0]] =
            '{from_state: from, evt: ev, nxt_state: to, act: act};
          fsm_count++;
          reply.ok = 1'b1;
        end
      end
      tdfsm_pkg::CMD_RESET: begin
        fsm_state = to;
        fsm_count = '0;
        reply.ok  = 1'b1;
      end
      default: begin
        fsm_state = to;
        reply.ok  = 1'b1;
      end
    endcase
    reply.cur_state = fsm_state;
    return reply;
  endfunction

  task automatic queue_cmd(logic [1:0] cmd, tdfsm_pkg::event_t ev, tdfsm_pkg::state_t from,
                           tdfsm_pkg::state_t to, tdfsm_pkg::action_t act);
    cmd_queue.push_back('{cmd: cmd, ev: ev, from: from, to: to, act: act});
  endtask

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch: %s expected %0d got %0d", what, want, got);
  endtask

  // Driver: presents queued commands, holds each until accepted, predicts on acceptance
  always @(posedge clk) begin : drive
    fsm_cmd_t nxt;
    logic     busy;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_gap    <= 0;
      fsm_state = '0;
      fsm_count = '0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(fsm_apply(in_cmd, in_event_code, in_from_state,
                                              in_to_state, in_action_id));
        accepted_cnt <= accepted_cnt + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          nxt = cmd_queue.pop_front();
          in_cmd        <= nxt.cmd;
          in_event_code <= nxt.ev;
          in_from_state <= nxt.from;
          in_to_state   <= nxt.to;
          in_action_id  <= nxt.act;
          in_valid      <= 1'b1;
          in_gap        <= (calm || $urandom_range(0, 9) < 4) ? 0 : pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side backpressure: random runs of stall and no stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(0, 2) != 0) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= pick_idle();
    end
  end

  // Monitor: compare each accepted result against the oldest prediction
  always @(posedge clk) begin : check
    tdfsm_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        note_mismatch("unexpected result, cur_state", 0, 32'(out_cur_state));
      end else begin
        want = predicted_replies.pop_front();
        if (out_ok !== want.ok) note_mismatch("ok", 32'(want.ok), 32'(out_ok));
        if (out_cur_state !== want.cur_state)
          note_mismatch("cur_state", 32'(want.cur_state), 32'(out_cur_state));
        if (out_action_out !== want.act)
          note_mismatch("action_out", 32'(want.act), 32'(out_action_out));
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned n_reg;
    int unsigned n_disp;
    int unsigned r;
    int unsigned episode;
    int unsigned target;

    // Directed: empty table, extremes, duplicates, set and reset
    queue_cmd(tdfsm_pkg::CMD_DISPATCH, 8'h00, 8'h00, 8'h00, 8'h00);  // empty table, no match
    queue_cmd(tdfsm_pkg::CMD_REGISTER, 8'h00, 8'h00, 8'hFF, 8'hFF);
    queue_cmd(tdfsm_pkg::CMD_REGISTER, 8'h00, 8'h00, 8'h01, 8'h07);  // duplicate, must lose
    queue_cmd(tdfsm_pkg::CMD_REGISTER, 8'hFF, 8'hFF, 8'h00, 8'h00);  // no-action entry
    queue_cmd(tdfsm_pkg::CMD_REGISTER, 8'h5A, 8'hFF, 8'hA5, 8'h80);
    queue_cmd(tdfsm_pkg::CMD_DISPATCH, 8'h00, 8'hFF, 8'hFF, 8'hFF);  // 0 -> FF
    queue_cmd(tdfsm_pkg::CMD_DISPATCH, 8'h00, 8'h00, 8'h00, 8'h00);  // no match in FF
    queue_cmd(tdfsm_pkg::CMD_DISPATCH, 8'hFF, 8'h00, 8'h00, 8'h00);  // FF -> 0, action 0
    queue_cmd(tdfsm_pkg::CMD_DISPATCH, 8'h00, 8'h00, 8'h00, 8'h00);  // 0 -> FF again
    queue_cmd(tdfsm_pkg::CMD_DISPATCH, 8'h5A, 8'hFF, 8'h00, 8'hFF);  // FF -> A5
    queue_cmd(tdfsm_pkg::CMD_SET,      8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(tdfsm_pkg::CMD_DISPATCH, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // FF -> 0
    queue_cmd(tdfsm_pkg::CMD_SET,      8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(tdfsm_pkg::CMD_RESET,    8'hFF, 8'hFF, 8'hFF, 8'hFF);  // clears table, state FF
    queue_cmd(tdfsm_pkg::CMD_DISPATCH, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // no match after clear
    queue_cmd(tdfsm_pkg::CMD_RESET,    8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(tdfsm_pkg::CMD_DISPATCH, 8'h00, 8'h00, 8'h00, 8'h00);

    // Random episodes: reset, build a table over a small state/event set, then run it
    target  = cmd_queue.size() + RANDOM_ITEMS;
    episode = 0;
    while (cmd_queue.size() < target) begin
      n_st = $urandom_range(2, 6);
      n_ev = $urandom_range(2, 6);
      for (int i = 0; i < 8; i++) begin
        st_pool[i[2:0]] = rand8();
        ev_pool[i[2:0]] = rand8();
      end
      queue_cmd(tdfsm_pkg::CMD_RESET, rand8(), rand8(), pick_st(), rand8());
      // every fifth episode, the first among them, fills the table and may run it past full
      n_reg = (episode % 5 == 0)
                ? $urandom_range(tdfsm_pkg::TABLE_DEPTH, tdfsm_pkg::TABLE_DEPTH + 4)
                : $urandom_range(1, 12);
      for (int i = 0; i < int'(n_reg); i++)
        queue_cmd(tdfsm_pkg::CMD_REGISTER, pick_ev(), pick_st(), pick_st(),
                  ($urandom_range(0, 7) == 0) ? 8'h00 : rand8());
      n_disp = $urandom_range(5, 25);
      for (int i = 0; i < int'(n_disp); i++) begin
        r = $urandom_range(0, 99);
        if (r < 75)
          queue_cmd(tdfsm_pkg::CMD_DISPATCH, pick_ev(), rand8(), rand8(), rand8());
        else if (r < 83)
          queue_cmd(tdfsm_pkg::CMD_DISPATCH, rand8(), rand8(), rand8(), rand8());
        else if (r < 88)
          queue_cmd(tdfsm_pkg::CMD_SET, rand8(), rand8(),
                    ($urandom_range(0, 3) == 0) ? rand8() : pick_st(), rand8());
        else if (r < 93)
          queue_cmd(tdfsm_pkg::CMD_REGISTER, pick_ev(), pick_st(), pick_st(), rand8());
        else
          queue_cmd(2'($urandom_range(0, 3)), rand8(), rand8(), rand8(), rand8());
      end
      episode++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_valid || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && predicted_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
